// ----- rtl/ale_pkg.sv -----
// Shared types, constants and saturation helper for the Legendre evaluator.
`timescale 1ns / 1ps
package ale_pkg;

    localparam int LMAX          = 12;
    localparam int OUT_FRAC_BITS = 24;
    localparam int MAGW          = 98;

    localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;
    localparam logic signed [31:0] MONE_Q30 = -32'sd1073741824;
    localparam logic [63:0]        ONE_OUT  = 64'd1 << OUT_FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQMUL,
        S_SQST,
        S_SQW,
        S_MLO,
        S_MHI,
        S_MFIN,
        S_SUB,
        S_AFTPMM,
        S_DIVST,
        S_DIVW,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        ST_PMM_K,
        ST_PMM_S,
        ST_PN_K,
        ST_PN_X,
        ST_LL_K,
        ST_LL_X,
        ST_LL_B
    } step_t;

    typedef struct packed {
        logic ready;
        logic res_valid;
    } ale_stat_t;

    // Returns {clipped, value} for a sign and a wide magnitude.
    function automatic logic [64:0] from_mag(input logic neg, input logic [MAGW-1:0] mag);
        logic [MAGW-1:0] lim;
        logic [63:0]     negv;
        logic [64:0]     r;
        lim  = MAGW'(1) << 63;
        negv = 64'd0 - mag[63:0];
        if (neg) begin
            if (mag >= lim) begin
                r = {(mag != lim), 1'b1, 63'd0};
            end else begin
                r = {1'b0, negv};
            end
        end else if (mag >= lim) begin
            r = {1'b1, 1'b0, {63{1'b1}}};
        end else begin
            r = {1'b0, mag[63:0]};
        end
        return r;
    endfunction

endpackage

// ----- rtl/ale_sqrt.sv -----
// Bit-serial integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module ale_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [60:0] radicand,
    output logic        done,
    output logic [30:0] root
);
    import ale_pkg::*;

    logic [61:0] rem_reg, rem_next;
    logic [61:0] res_reg, res_next;
    logic [61:0] bit_reg, bit_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [61:0] trial;

    always_comb
    begin
        trial     = res_reg + bit_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = {1'b0, radicand};
            res_next  = 62'd0;
            bit_next  = 62'd1 << 60;
            cnt_next  = 5'd30;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign root = res_reg[30:0];

endmodule

// ----- rtl/ale_div.sv -----
// Radix-16 restoring divider of a 64-bit magnitude by a small divisor.
`timescale 1ns / 1ps
module ale_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [3:0]  divisor,
    output logic        done,
    output logic [63:0] quotient
);
    import ale_pkg::*;

    logic [63:0] nq_reg, nq_next;
    logic [3:0]  rem_reg, rem_next;
    logic [3:0]  d_reg, d_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  r;
    logic [4:0]  t;
    logic [3:0]  qb;

    always_comb
    begin
        r  = rem_reg;
        t  = 5'd0;
        qb = 4'd0;
        for (int j = 3; j >= 0; j--) begin
            t = {r, nq_reg[60 + j]};
            if (t >= {1'b0, d_reg}) begin
                r     = 4'(t - {1'b0, d_reg});
                qb[j] = 1'b1;
            end else begin
                r = t[3:0];
            end
        end
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            nq_next   = dividend;
            rem_next  = 4'd0;
            d_next    = divisor;
            cnt_next  = 4'd15;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            nq_next  = {nq_reg[59:0], qb};
            rem_next = r;
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = nq_reg;

endmodule

// ----- rtl/ale_core.sv -----
// Sequencer and shared multiplier datapath for the Legendre recurrence.
`timescale 1ns / 1ps
module ale_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [3:0]        l_in,
    input  logic [3:0]        m_in,
    input  logic signed [31:0] x_in,
    input  logic              res_ready,
    output ale_pkg::ale_stat_t stat,
    output logic [63:0]       res_value,
    output logic              res_ovf
);
    import ale_pkg::*;

    state_t state_reg, state_next;
    step_t  step_reg;

    logic [3:0]        l_reg, m_reg, i_reg, ll_reg;
    logic signed [31:0] x_reg, x_clamp;
    logic [63:0]       work_reg, pmm_reg, pnext_reg, a_reg;
    logic [63:0]       p0_reg, mul_p_reg;
    logic [30:0]       s_reg;
    logic              flag_reg, dneg_reg;
    logic              invalid;

    logic [63:0] ma;
    logic [4:0]  k;
    logic [30:0] mb, xmag;
    logic        q30, bneg;
    logic [31:0] mul_x, mul_y;
    logic [64:0] p0r;
    logic [34:0] hi35;
    logic [MAGW-1:0] mwide;
    logic [64:0] mres, dres;
    logic [63:0] sa;
    logic [64:0] sdiff;
    logic [63:0] sres;
    logic        sflag;
    logic [3:0]  k_div;
    logic [63:0] div_in;
    logic        sq_done, div_done;
    logic [30:0] root;
    logic [63:0] quot;
    logic [32:0] one_m_x, one_p_x;

    assign invalid = (m_in > l_in) || (l_in > 4'(LMAX)) || (m_in > 4'(LMAX));

    always_comb
    begin
        if (x_in > ONE_Q30) begin
            x_clamp = ONE_Q30;
        end else if (x_in < MONE_Q30) begin
            x_clamp = MONE_Q30;
        end else begin
            x_clamp = x_in;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        ma   = work_reg[63] ? (64'd0 - work_reg) : work_reg;
        xmag = x_reg[31] ? 31'(33'd0 - {x_reg[31], x_reg}) : x_reg[30:0];
        k    = 5'd1;
        mb   = 31'd0;
        q30  = 1'b0;
        bneg = 1'b0;
        case (step_reg)
            ST_PMM_K: k = {i_reg, 1'b0} - 5'd1;
            ST_PN_K:  k = {m_reg, 1'b0} + 5'd1;
            ST_LL_K:  k = {ll_reg, 1'b0} - 5'd1;
            ST_LL_B:  k = 5'({1'b0, ll_reg} + {1'b0, m_reg} - 5'd1);
            default:  k = 5'd1;
        endcase
        case (step_reg)
            ST_PMM_S:
            begin
                mb  = s_reg;
                q30 = 1'b1;
            end
            ST_PN_X, ST_LL_X:
            begin
                mb   = xmag;
                q30  = 1'b1;
                bneg = x_reg[31];
            end
            default: mb = {26'd0, k};
        endcase
        one_m_x = {ONE_Q30[31], ONE_Q30} - {x_reg[31], x_reg};
        one_p_x = {ONE_Q30[31], ONE_Q30} + {x_reg[31], x_reg};
        if (state_reg == S_SQMUL) begin
            mul_x = one_m_x[31:0];
            mul_y = one_p_x[31:0];
        end else if (state_reg == S_MHI) begin
            mul_x = ma[63:32];
            mul_y = {1'b0, mb};
        end else begin
            mul_x = ma[31:0];
            mul_y = {1'b0, mb};
        end
    end

    always_comb
    begin
        p0r  = {1'b0, p0_reg} + (65'd1 << 29);
        hi35 = p0r[64:30];
        if (q30) begin
            mwide = {32'd0, mul_p_reg, 2'd0} + {63'd0, hi35};
        end else begin
            mwide = {2'd0, mul_p_reg, 32'd0} + {34'd0, p0_reg};
        end
        mres = from_mag(work_reg[63] ^ bneg, mwide);

        sa    = (step_reg == ST_PMM_S) ? 64'd0 : a_reg;
        sdiff = {sa[63], sa} - {work_reg[63], work_reg};
        sflag = sdiff[64] != sdiff[63];
        if (sflag) begin
            sres = sdiff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sres = sdiff[63:0];
        end

        k_div  = ll_reg - m_reg;
        div_in = ma + {61'd0, k_div[3:1]};
        dres   = from_mag(dneg_reg, {34'd0, quot});
    end

    ale_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_SQST),
        .radicand (mul_p_reg[60:0]),
        .done     (sq_done),
        .root     (root)
    );

    ale_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DIVST),
        .dividend (div_in),
        .divisor  (k_div),
        .done     (div_done),
        .quotient (quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start) begin
                    if (invalid) begin
                        state_next = S_DONE;
                    end else if (m_in == 4'd0) begin
                        state_next = S_AFTPMM;
                    end else begin
                        state_next = S_SQMUL;
                    end
                end
            end
            S_SQMUL: state_next = S_SQST;
            S_SQST:  state_next = S_SQW;
            S_SQW:
            begin
                if (sq_done) begin
                    state_next = S_MLO;
                end
            end
            S_MLO: state_next = S_MHI;
            S_MHI: state_next = S_MFIN;
            S_MFIN:
            begin
                case (step_reg)
                    ST_PMM_S, ST_LL_B: state_next = S_SUB;
                    ST_PN_X:
                    begin
                        if ({1'b0, l_reg} == {1'b0, m_reg} + 5'd1) begin
                            state_next = S_DONE;
                        end else begin
                            state_next = S_MLO;
                        end
                    end
                    default: state_next = S_MLO;
                endcase
            end
            S_SUB:
            begin
                if (step_reg == ST_PMM_S) begin
                    state_next = (i_reg == m_reg) ? S_AFTPMM : S_MLO;
                end else begin
                    state_next = S_DIVST;
                end
            end
            S_AFTPMM: state_next = (l_reg == m_reg) ? S_DONE : S_MLO;
            S_DIVST:  state_next = S_DIVW;
            S_DIVW:
            begin
                if (div_done) begin
                    state_next = (ll_reg == l_reg) ? S_DONE : S_MLO;
                end
            end
            S_DONE:
            begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        stat.ready     = (state_reg == S_IDLE);
        stat.res_valid = (state_reg == S_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_x * mul_y;
        case (state_reg)
            S_IDLE:
            begin
                if (start) begin
                    l_reg    <= l_in;
                    m_reg    <= m_in;
                    x_reg    <= x_clamp;
                    work_reg <= invalid ? 64'd0 : ONE_OUT;
                    pmm_reg  <= ONE_OUT;
                    i_reg    <= 4'd1;
                    flag_reg <= 1'b0;
                    step_reg <= ST_PMM_K;
                end
            end
            S_SQW:
            begin
                if (sq_done) begin
                    s_reg    <= root;
                    step_reg <= ST_PMM_K;
                end
            end
            S_MHI: p0_reg <= mul_p_reg;
            S_MFIN:
            begin
                flag_reg <= flag_reg | mres[64];
                case (step_reg)
                    ST_PMM_K:
                    begin
                        work_reg <= mres[63:0];
                        step_reg <= ST_PMM_S;
                    end
                    ST_PN_K:
                    begin
                        work_reg <= mres[63:0];
                        step_reg <= ST_PN_X;
                    end
                    ST_PN_X:
                    begin
                        work_reg  <= mres[63:0];
                        pnext_reg <= mres[63:0];
                        ll_reg    <= m_reg + 4'd2;
                        step_reg  <= ST_LL_K;
                    end
                    ST_LL_K:
                    begin
                        work_reg <= mres[63:0];
                        step_reg <= ST_LL_X;
                    end
                    ST_LL_X:
                    begin
                        a_reg    <= mres[63:0];
                        work_reg <= pmm_reg;
                        step_reg <= ST_LL_B;
                    end
                    default: work_reg <= mres[63:0];
                endcase
            end
            S_SUB:
            begin
                flag_reg <= flag_reg | sflag;
                work_reg <= sres;
                if (step_reg == ST_PMM_S) begin
                    pmm_reg  <= sres;
                    i_reg    <= i_reg + 4'd1;
                    step_reg <= ST_PMM_K;
                end
            end
            S_AFTPMM: step_reg <= ST_PN_K;
            S_DIVST:  dneg_reg <= work_reg[63];
            S_DIVW:
            begin
                if (div_done) begin
                    flag_reg  <= flag_reg | dres[64];
                    pmm_reg   <= pnext_reg;
                    pnext_reg <= dres[63:0];
                    work_reg  <= dres[63:0];
                    ll_reg    <= ll_reg + 4'd1;
                    step_reg  <= ST_LL_K;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res_value = work_reg;
    assign res_ovf   = flag_reg;

endmodule

// ----- rtl/associated_legendre_eval_unit.sv -----
// Top level of the associated Legendre evaluator with stream ports.
// For m above l or out of range the sequencer goes straight to its done state and returns zero.
// Each order step runs on the shared 32x32 multiplier, after a square root.
// Each recurrence step uses three two-pass multiplies, a subtraction and the divider.
// One word is in flight at a time; the input is ready again once the result is registered.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and empties the output.
`timescale 1ns / 1ps
module associated_legendre_eval_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // l_degree[3:0], m_order[7:4], x_arg[39:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // plm_value[63:0]
    output logic [0:0]  m_tuser    // overflow[0]
);
    import ale_pkg::*;

    ale_stat_t   stat;
    logic [63:0] res_value;
    logic        res_ovf;
    logic        res_ready;
    logic        m_tvalid_reg;
    logic [63:0] data_reg;
    logic        ovf_reg;

    assign res_ready = !m_tvalid_reg || m_tready;
    assign s_tready  = stat.ready;

    ale_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_tvalid && stat.ready),
        .l_in      (s_tdata[3:0]),
        .m_in      (s_tdata[7:4]),
        .x_in      (s_tdata[39:8]),
        .res_ready (res_ready),
        .stat      (stat),
        .res_value (res_value),
        .res_ovf   (res_ovf)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_tvalid_reg <= 1'b0;
        end else if (stat.res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.res_valid && res_ready) begin
            data_reg <= res_value;
            ovf_reg  <= res_ovf;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = data_reg;
    assign m_tuser[0] = ovf_reg;

endmodule
